FILE: hdl/slms_pkg.sv
// ============================================================================
// slms_pkg
// Shared types and constants for the scrolling LED matrix scanner.
// ============================================================================
`default_nettype none

package slms_pkg;

    // Geometry of the display and the character window.
    localparam int unsigned GLYPH_COLS   = 5;
    localparam int unsigned WINDOW_CHARS = 5;
    localparam int unsigned WIN_DEPTH    = GLYPH_COLS * WINDOW_CHARS;
    localparam int unsigned WIN_IW       = $clog2(WIN_DEPTH);

    // Window index where a newly entering character lands after a shift.
    localparam logic [WIN_IW-1:0] SHIFT_BASE = WIN_IW'(WIN_DEPTH - GLYPH_COLS);

    localparam logic [7:0] SPEED_RESET = 8'd50;

    // Command codes of an input item.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // Configuration register indexes.
    localparam logic REG_SCROLL_SPEED   = 1'b0;
    localparam logic REG_MESSAGE_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] char_index;
        logic [2:0] column_index;
        logic [7:0] column_bits;
    } t_in_item;

    typedef struct packed {
        logic [7:0] row_bits;
        logic [2:0] column_select;
        logic [1:0] block_select;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hdl/slms_ram.sv
// ============================================================================
// slms_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module slms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 320,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/scrolling_led_matrix_scanner.sv
// ============================================================================
// scrolling_led_matrix_scanner
// Column scanner for a scrolling message shown on four multiplexed 5-column
// LED character blocks, with a message store and a five-character window.
// ============================================================================
//
//  Channel   Direction  Handshake                 Contents
//  --------  ---------  ------------------------  ---------------------------
//  input     in         i_in_valid / o_in_ready   command, char, column, bits
//  output    out        o_out_valid / i_out_ready row bits, column, block
//  config    in         i_cfg_we                  scroll speed, message length
//
// A load or an unused command stays in idle; a load writes the message RAM at its transfer.
// A tick passes through its compute state, then a fill when the window shifts: the entering
// character is read through the single RAM read port one glyph column per cycle, then a drain
// state takes the last read data. A start on an empty message stays idle; otherwise it fills
// up to five characters, then drains. Reset clears the window, scan counters and registers,
// never the message RAM. A tick waits in its compute state while the output register is full.
// ============================================================================
`default_nettype none

module scrolling_led_matrix_scanner #(
    parameter int MAX_CHARS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire slms_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output slms_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    // Width of a message character pointer and of a message RAM address.
    localparam int CW      = $clog2(MAX_CHARS);
    localparam int AW      = $clog2(MAX_CHARS * 5);
    localparam int MAX_LEN = (MAX_CHARS > 127) ? 127 : MAX_CHARS;
    localparam int CMPW    = (CW + 1 > 7) ? CW + 1 : 7;
    localparam int WIW     = slms_pkg::WIN_IW;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TICK  = 4'b0010,
        S_FILL  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_speed;
    logic [6:0]       r_len;
    logic [7:0]       r_win [slms_pkg::WIN_DEPTH];
    logic [7:0]       n_win [slms_pkg::WIN_DEPTH];
    logic [1:0]       r_blk, n_blk;
    logic [2:0]       r_col, n_col;
    logic [2:0]       r_scr, n_scr;
    logic [7:0]       r_spd, n_spd;
    logic [CW-1:0]    r_next, n_next;
    logic [AW-1:0]    r_addr, n_addr;
    logic [WIW-1:0]   r_widx, n_widx;
    logic [WIW-1:0]   r_cnt, n_cnt;
    logic             r_rd_pend;
    logic [WIW-1:0]   r_rd_widx;
    logic             r_out_valid, n_out_valid;
    slms_pkg::t_out_item r_out, n_out;

    logic             in_xfer;
    logic [6:0]       eff_len;
    logic             out_space;
    logic [4:0]       pos;
    logic [2:0]       slot;
    logic [4:0]       slot_base;
    logic             gap;
    logic [WIW-1:0]   rd_idx;
    logic [7:0]       row;
    logic [7:0]       spd_inc;
    logic [CW-1:0]    ch_sel;
    logic [CW:0]      ch_inc;
    logic [CW-1:0]    start_next;
    logic [WIW-1:0]   start_cnt;
    logic             ld_we;
    logic [8:0]       ld_addr9;
    logic [7:0]       ram_rdata;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_space = !r_out_valid || i_out_ready;

    // Message lengths beyond the store capacity act as the capacity.
    assign eff_len = (r_len > 7'(MAX_LEN)) ? 7'(MAX_LEN) : r_len;

    // Load address is char * 5 + column, formed with a shift and an add.
    assign ld_addr9 = {1'b0, i_in_data.char_index, 2'b00} + {3'b000, i_in_data.char_index}
                    + {6'b0, i_in_data.column_index};
    assign ld_we    = in_xfer && (i_in_data.command == slms_pkg::CMD_LOAD)
                    && (i_in_data.column_index < 3'(slms_pkg::GLYPH_COLS))
                    && ({3'b000, i_in_data.char_index} < 9'(MAX_CHARS));

    slms_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHARS * 5),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (AW'(ld_addr9)),
        .i_wdata (i_in_data.column_bits),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Scan position in column slots: block * 6 + column + scroll. Each
    // character owns six slots, the last of which is the blank gap.
    assign pos = 5'({r_blk, 2'b00}) + 5'({r_blk, 1'b0}) + 5'(r_col) + 5'(r_scr);

    always_comb begin
        if (pos >= 5'd24) begin
            slot = 3'd4;
        end else if (pos >= 5'd18) begin
            slot = 3'd3;
        end else if (pos >= 5'd12) begin
            slot = 3'd2;
        end else if (pos >= 5'd6) begin
            slot = 3'd1;
        end else begin
            slot = 3'd0;
        end
    end

    assign slot_base = 5'({slot, 2'b00}) + 5'({slot, 1'b0});
    assign gap       = (pos - slot_base) == 5'd5;
    // The window holds five columns per character, so the gap slots drop out.
    assign rd_idx    = WIW'(pos - 5'(slot));
    assign row       = gap ? 8'd0 : r_win[rd_idx];

    assign spd_inc = r_spd + 8'd1;

    // Character that enters on a shift; a stale pointer falls back to zero.
    assign ch_sel = (CMPW'(r_next) >= CMPW'(eff_len)) ? '0 : r_next;
    assign ch_inc = {1'b0, ch_sel} + (CW + 1)'(1);

    // After a start the next character is five modulo the length.
    always_comb begin
        case (eff_len)
            7'd0, 7'd1, 7'd5: start_next = '0;
            7'd2, 7'd4:       start_next = CW'(1);
            7'd3:             start_next = CW'(2);
            default:          start_next = CW'(5);
        endcase
    end

    always_comb begin
        case (eff_len)
            7'd0:    start_cnt = WIW'(0);
            7'd1:    start_cnt = WIW'(5);
            7'd2:    start_cnt = WIW'(10);
            7'd3:    start_cnt = WIW'(15);
            7'd4:    start_cnt = WIW'(20);
            default: start_cnt = WIW'(slms_pkg::WIN_DEPTH);
        endcase
    end

    // Sequencer: one RAM read per cycle through the shared address counter.
    always_comb begin
        n_state     = r_state;
        n_blk       = r_blk;
        n_col       = r_col;
        n_scr       = r_scr;
        n_spd       = r_spd;
        n_next      = r_next;
        n_addr      = r_addr;
        n_widx      = r_widx;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_win       = r_win;

        // Read data of the previous fill cycle lands in the window.
        if (r_rd_pend) begin
            n_win[r_rd_widx] = ram_rdata;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.command)
                        slms_pkg::CMD_TICK: begin
                            n_state = S_TICK;
                        end
                        slms_pkg::CMD_START: begin
                            for (int k = 0; k < slms_pkg::WIN_DEPTH; k++) begin
                                n_win[k] = 8'd0;
                            end
                            n_blk  = '0;
                            n_col  = '0;
                            n_scr  = '0;
                            n_spd  = '0;
                            n_next = start_next;
                            n_addr = '0;
                            n_widx = '0;
                            n_cnt  = start_cnt;
                            if (start_cnt != '0) begin
                                n_state = S_FILL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (out_space) begin
                    n_out_valid         = 1'b1;
                    n_out.row_bits      = row;
                    n_out.column_select = r_col;
                    n_out.block_select  = r_blk;
                    n_state             = S_IDLE;
                    n_blk               = r_blk + 2'd1;
                    if (r_blk == 2'd3) begin
                        n_col = r_col + 3'd1;
                        if (r_col == 3'(slms_pkg::GLYPH_COLS - 1)) begin
                            n_col = '0;
                            if (eff_len > 7'd4) begin
                                n_spd = spd_inc;
                                if (spd_inc == r_speed) begin
                                    n_spd = '0;
                                    n_scr = r_scr + 3'd1;
                                    if (r_scr == 3'd5) begin
                                        // Shift the window left by one
                                        // character and fetch the next one.
                                        n_scr = '0;
                                        for (int k = 0; k < int'(slms_pkg::SHIFT_BASE);
                                             k++) begin
                                            n_win[k] = r_win[k + slms_pkg::GLYPH_COLS];
                                        end
                                        n_addr  = AW'({ch_sel, 2'b00}) + AW'(ch_sel);
                                        n_widx  = slms_pkg::SHIFT_BASE;
                                        n_cnt   = WIW'(slms_pkg::GLYPH_COLS);
                                        n_next  = (CMPW'(ch_inc) >= CMPW'(eff_len))
                                                ? '0 : CW'(ch_inc);
                                        n_state = S_FILL;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            S_FILL: begin
                n_addr = r_addr + AW'(1);
                n_widx = r_widx + WIW'(1);
                n_cnt  = r_cnt - WIW'(1);
                if (r_cnt == WIW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= slms_pkg::SPEED_RESET;
            r_len       <= '0;
            r_blk       <= '0;
            r_col       <= '0;
            r_scr       <= '0;
            r_spd       <= '0;
            r_next      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < slms_pkg::WIN_DEPTH; k++) begin
                r_win[k] <= 8'd0;
            end
        end else begin
            r_state     <= n_state;
            r_blk       <= n_blk;
            r_col       <= n_col;
            r_scr       <= n_scr;
            r_spd       <= n_spd;
            r_next      <= n_next;
            r_rd_pend   <= (r_state == S_FILL);
            r_out_valid <= n_out_valid;
            r_win       <= n_win;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    slms_pkg::REG_SCROLL_SPEED:   r_speed <= i_cfg_data;
                    slms_pkg::REG_MESSAGE_LENGTH: r_len   <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_widx    <= n_widx;
        r_cnt     <= n_cnt;
        r_rd_widx <= r_widx;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: hdl/slms_checker.sv
// ============================================================================
// slms_checker
// Port-level checks for the scrolling LED matrix scanner.
// ============================================================================
`default_nettype none

module slms_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire slms_pkg::t_in_item  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire slms_pkg::t_out_item o_out_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid && o_in_ready;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // The scanned column never reaches the gap column.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.column_select <= 3'd4)
        else $error("column select out of range");

    // A tick keeps the input side busy at least through its compute state.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.command == slms_pkg::CMD_TICK |=> !o_in_ready)
        else $error("input ready right after a tick");

    // Loads, starts and unused commands never produce a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.command != slms_pkg::CMD_TICK && !o_out_valid
        |=> !o_out_valid)
        else $error("result raised by a non-tick item");

endmodule

bind scrolling_led_matrix_scanner slms_checker u_slms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

FILE: test/tb_scrolling_led_matrix_scanner.sv
// ============================================================================
// tb_scrolling_led_matrix_scanner
// Self-checking bench for the scrolling LED matrix scanner. A short directed
// table comes first. Random phases follow, each with its own scroll speed and
// message length. Every result is checked against a cycle-free model of the
// scan, the window fill and the scroll logic.
// ============================================================================

module tb_scrolling_led_matrix_scanner;

    import slms_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants. The block is built with its default capacity, so the
    // model uses the same number of message characters.
    // ------------------------------------------------------------------------
    localparam int MAX_CHARS  = 64;
    localparam int SLOT_COLS  = 6;    // five glyph columns plus one blank gap
    localparam int NUM_BLOCKS = 4;
    localparam int ITEM_GOAL  = 1950;
    // A start copies up to five characters, and the settle stretch covers any start,
    // load or shifting tick that is still running.
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    // Command code 3 has no meaning in the block. It is used here as noise.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

    // One row of the directed table. A row is either an input item or a
    // register write. Rows flagged as typed carry a result that can be read
    // off directly. All other rows are checked against the model.
    typedef struct packed {
        row_kind_e  kind;
        t_in_item   item;
        logic       typed;
        t_out_item  want;
        logic       cfg_idx;
        logic [7:0] cfg_val;
    } script_row_t;

    localparam int SCRIPT_LEN = 25;

    // ------------------------------------------------------------------------
    // Signals to and from the block. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data  = 8'd0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;

    scrolling_led_matrix_scanner uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin : clock_gen
        forever #2 clk = ~clk;
    end

    // The limit is far above the slowest legal run, even with every stall at
    // its longest.
    initial begin : watchdog
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Scan model. It keeps its own copy of the message store, the character
    // window, the scan counters and both registers.
    // ------------------------------------------------------------------------
    logic [7:0]            msg_mem [MAX_CHARS*GLYPH_COLS];
    logic [7:0]            win_cols [WIN_DEPTH];
    logic [1:0]            blk_cnt;
    logic [2:0]            col_cnt;
    logic [2:0]            scroll_pos;
    logic [7:0]            pass_cnt;
    logic [5:0]            next_chr;
    logic [7:0]            speed_reg;
    logic [6:0]            length_reg;

    t_out_item pending_columns [$];   // expected scan outputs, oldest first
    int        mismatch_count = 0;
    int        driven_items   = 0;    // items that the block acts on
    bit        gaps_on        = 1'b1;
    int        burst_left     = 0;
    bit        hold_req       = 1'b0;
    bit        rx_open        = 1'b0;

    // A length above the store capacity behaves as a full store.
    function automatic int active_len();
        return (int'(length_reg) > MAX_CHARS) ? MAX_CHARS : int'(length_reg);
    endfunction

    function automatic void fill_slot(input int slot, input int chr);
        for (int j = 0; j < GLYPH_COLS; j++)
            win_cols[slot*GLYPH_COLS + j] = msg_mem[chr*GLYPH_COLS + j];
    endfunction

    // A start loads the first five characters, blanks any slot past the end
    // of a short message and clears every counter.
    function automatic void restart_window();
        int len;
        len = active_len();
        foreach (win_cols[i]) win_cols[i] = 8'h00;
        for (int i = 0; i < WINDOW_CHARS; i++)
            if (i < len) fill_slot(i, i);
        next_chr   = (len == 0) ? 6'd0 : 6'(int'(WINDOW_CHARS) % len);
        blk_cnt    = '0;
        col_cnt    = '0;
        scroll_pos = '0;
        pass_cnt   = '0;
    endfunction

    // The window moves left by one character. A pointer that fell past a
    // shortened message brings in character zero instead.
    function automatic void shift_in();
        int len;
        int chr;
        len = active_len();
        chr = int'(next_chr);
        for (int i = 0; i < WIN_DEPTH - GLYPH_COLS; i++)
            win_cols[i] = win_cols[i + GLYPH_COLS];
        if (chr >= len) chr = 0;
        fill_slot(WINDOW_CHARS - 1, chr);
        chr++;
        next_chr = (chr >= len) ? 6'd0 : 6'(chr);
    endfunction

    // Returns 1 when the item produces a scan output, which then goes to res.
    function automatic bit predict_scan(input t_in_item it, output t_out_item res);
        int pos;
        int slot;
        int sc;
        res = '0;
        case (it.command)
            CMD_LOAD: begin
                // Column numbers past the glyph width are dropped.
                if (it.column_index < GLYPH_COLS)
                    msg_mem[int'(it.char_index)*GLYPH_COLS + int'(it.column_index)] =
                        it.column_bits;
                return 1'b0;
            end
            CMD_START: begin
                restart_window();
                return 1'b0;
            end
            CMD_TICK: begin
                pos  = int'(blk_cnt)*SLOT_COLS + int'(col_cnt) + int'(scroll_pos);
                slot = pos / SLOT_COLS;
                sc   = pos % SLOT_COLS;
                // The sixth column of each slot is the blank gap.
                if (sc < GLYPH_COLS && slot < WINDOW_CHARS)
                    res.row_bits = win_cols[slot*GLYPH_COLS + sc];
                res.column_select = col_cnt;
                res.block_select  = blk_cnt;
                if (int'(blk_cnt) == NUM_BLOCKS - 1) begin
                    blk_cnt = '0;
                    if (int'(col_cnt) == GLYPH_COLS - 1) begin
                        col_cnt = '0;
                        // Only messages longer than four characters scroll.
                        if (active_len() > 4) begin
                            // An 8-bit pass counter: a speed of zero, or a
                            // count above a lowered speed, runs through the wrap.
                            pass_cnt = pass_cnt + 8'd1;
                            if (pass_cnt == speed_reg) begin
                                pass_cnt = '0;
                                if (int'(scroll_pos) == SLOT_COLS - 1) begin
                                    scroll_pos = '0;
                                    shift_in();
                                end else begin
                                    scroll_pos = scroll_pos + 3'd1;
                                end
                            end
                        end
                    end else begin
                        col_cnt = col_cnt + 3'd1;
                    end
                end else begin
                    blk_cnt = blk_cnt + 2'd1;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (pending_columns.size() == 0) begin
            $error("unexpected result: row_bits 8'h%02h column_select %0d block_select %0d",
                   got.row_bits, got.column_select, got.block_select);
            mismatch_count++;
            return;
        end
        want = pending_columns.pop_front();
        if (got.row_bits !== want.row_bits) begin
            $error("row_bits: expected 8'h%02h, got 8'h%02h", want.row_bits, got.row_bits);
            mismatch_count++;
        end
        if (got.column_select !== want.column_select) begin
            $error("column_select: expected %0d, got %0d",
                   want.column_select, got.column_select);
            mismatch_count++;
        end
        if (got.block_select !== want.block_select) begin
            $error("block_select: expected %0d, got %0d", want.block_select, got.block_select);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Items go out in bursts of random length with random gaps
    // between them while gaps are enabled. An item counts as sent at the edge
    // of its transfer, and only then does the model take it.
    // ------------------------------------------------------------------------
    task automatic offer(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item res;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            in_valid  <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0) burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (o_in_ready !== 1'b1) @(posedge clk);
        if (predict_scan(it, res)) pending_columns.push_back(typed ? want : res);
        if (it.command != CMD_SPARE && !(it.command == CMD_LOAD && it.column_index >= GLYPH_COLS))
            driven_items++;
    endtask

    // Holds the input side idle until every expected result has arrived, and
    // then lets a start or a shift still running inside the block finish.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_SCROLL_SPEED) speed_reg = val;
        else                         length_reg = val[6:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A random item. Loads use legal columns, except for a small share of
    // out-of-range columns and spare commands, which the block must ignore.
    function automatic t_in_item rand_item(input int tick_pct, input int start_pct);
        t_in_item it;
        int       pick;
        it   = $bits(t_in_item)'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < tick_pct) begin
            it.command = CMD_TICK;
        end else if (pick < tick_pct + start_pct) begin
            it.command = CMD_START;
        end else if (pick < 96) begin
            it.command      = CMD_LOAD;
            it.column_index = 3'($urandom_range(0, GLYPH_COLS - 1));
        end else if (pick < 98) begin
            it.command      = CMD_LOAD;
            it.column_index = 3'($urandom_range(GLYPH_COLS, 7));
        end else begin
            it.command = CMD_SPARE;
        end
        return it;
    endfunction

    // One phase of the random part: the block is drained, both registers are
    // written, a start is sent if asked, and then mostly ticks follow. hold_at names
    // the item at which the output side is asked for a long hold-off, or -1 for none.
    task automatic run_phase(input logic [7:0] speed, input logic [7:0] len,
                             input bit restart, input int count, input int start_pct,
                             input bit gaps, input int hold_at);
        t_in_item start_item;
        drain();
        write_reg(REG_SCROLL_SPEED, speed);
        write_reg(REG_MESSAGE_LENGTH, len);
        gaps_on = gaps;
        if (restart) begin
            start_item         = rand_item(0, 0);
            start_item.command = CMD_START;
            offer(start_item, 1'b0, '0);
        end
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_req = 1'b1;
            offer(rand_item(90 - start_pct, start_pct), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table. It runs with the reset register values: speed 50 and
    // an empty message. It covers ticks on the reset window, extreme field
    // values, loads with an out-of-range column, the spare command, a start
    // on an empty message, and a one-character message padded with blanks.
    // ------------------------------------------------------------------------
    script_row_t script_rows [SCRIPT_LEN] = '{
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd0},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd63, 3'd7, 8'hFF}, 1'b1, '{8'h00, 3'd0, 2'd1},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_SPARE, 6'd21, 3'd2, 8'h3C}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd63, 3'd4, 8'hFF}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd0,  3'd0, 8'h00}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd0,  3'd5, 8'hA5}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd63, 3'd7, 8'h5A}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd1,  3'd6, 8'hFF}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_START, 6'd0,  3'd0, 8'h00}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd0},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd1},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd2},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd3},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd1, 2'd0},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd0,  3'd1, 8'h81}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd0,  3'd2, 8'h42}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd0,  3'd3, 8'h24}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_LOAD,  6'd0,  3'd4, 8'h18}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_CFG,  '0, 1'b0, '0, REG_MESSAGE_LENGTH, 8'd1},
        '{ROW_ITEM, '{CMD_START, 6'd0,  3'd0, 8'h00}, 1'b0, '0, REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd0},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd1},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd2},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h00, 3'd0, 2'd3},
          REG_SCROLL_SPEED, 8'd0},
        '{ROW_ITEM, '{CMD_TICK,  6'd0,  3'd0, 8'h00}, 1'b1, '{8'h81, 3'd1, 2'd0},
          REG_SCROLL_SPEED, 8'd0}
    };

    // ------------------------------------------------------------------------
    // Output side. Each result is checked at the edge of its transfer. The
    // ready line follows a stall pattern of its own: always open, random, or
    // periodic, with a new pattern drawn at random intervals. On request it holds off
    // for a long stretch so that the block fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        rx_mode_e stall_mode;
        int       mode_left;
        int       period;
        int       low_len;
        int       phase_cnt;
        int       hold_left;
        stall_mode = RX_OPEN;
        mode_left  = 0;
        period     = 4;
        low_len    = 1;
        phase_cnt  = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && o_out_valid === 1'b1 && out_ready) check_result(o_out_data);
            if (mode_left == 0) begin
                stall_mode = rx_mode_e'($urandom_range(0, 2));
                mode_left  = $urandom_range(100, 400);
                period     = $urandom_range(2, 7);
                low_len    = $urandom_range(1, period - 1);
            end
            mode_left--;
            phase_cnt = (phase_cnt + 1) % period;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (rx_open) begin
                out_ready <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= ($urandom_range(0, 99) < 60);
                    default:   out_ready <= (phase_cnt >= low_len);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. The model starts from the reset state of the block. The
    // message store is all zero here, but no entry is read before it has
    // been written.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_in_item it;
        int       rand_phases;
        logic [7:0] speed;
        logic [7:0] len;
        int       pick;

        foreach (msg_mem[i]) msg_mem[i] = 8'h00;
        foreach (win_cols[i]) win_cols[i] = 8'h00;
        blk_cnt    = '0;
        col_cnt    = '0;
        scroll_pos = '0;
        pass_cnt   = '0;
        next_chr   = '0;
        speed_reg  = SPEED_RESET;
        length_reg = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[r]) begin
            if (script_rows[r].kind == ROW_CFG) begin
                drain();
                write_reg(script_rows[r].cfg_idx, script_rows[r].cfg_val);
            end else begin
                offer(script_rows[r].item, script_rows[r].typed, script_rows[r].want);
            end
        end

        // Fill the whole message store with random glyphs, so that any later
        // message length reads only written entries. Ticks and noise are mixed
        // in. The message is one character long here, and character zero is
        // already loaded.
        for (int c = 0; c < MAX_CHARS; c++) begin
            if (c % 8 == 0) gaps_on = $urandom_range(0, 1);
            for (int j = 0; j < GLYPH_COLS; j++) begin
                it              = rand_item(0, 0);
                it.command      = CMD_LOAD;
                it.char_index   = 6'(c);
                it.column_index = 3'(j);
                offer(it, 1'b0, '0);
                pick = $urandom_range(0, 99);
                if (pick < 12) offer(rand_item(100, 0), 1'b0, '0);
                else if (pick < 15) offer(rand_item(0, 0), 1'b0, '0);
            end
        end

        // A five-character message at the fastest speed. It runs long enough
        // for the window to shift past its last character and wrap to the
        // first one. At item 300, the output side holds off.
        run_phase(8'd1, 8'd5, 1'b1, 760, 0, 1'b1, 300);
        // A full-capacity message, without gaps: the pointer moves past five.
        run_phase(8'd1, 8'd64, 1'b1, 150, 0, 1'b0, -1);
        // The length drops below the pointer without a new start, so the
        // next shift brings in character zero.
        run_phase(8'd1, 8'd5, 1'b0, 200, 0, 1'b1, -1);
        // Slowest nonzero speed, with a length above the store capacity.
        run_phase(8'd255, 8'd100, 1'b1, 150, 0, 1'b1, -1);
        // Speed zero while the pass count already sits above it.
        run_phase(8'd0, 8'd7, 1'b0, 100, 0, 1'b0, -1);
        // Short and empty messages do not scroll.
        run_phase(8'd3, 8'd3, 1'b1, 80, 2, 1'b1, -1);
        run_phase(8'd1, 8'd0, 1'b1, 40, 2, 1'b1, -1);

        rand_phases = 0;
        while (driven_items < ITEM_GOAL || rand_phases < 2) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)      speed = 8'd1;
            else if (pick < 6) speed = 8'($urandom_range(1, 4));
            else if (pick < 8) speed = 8'($urandom_range(1, 255));
            else if (pick < 9) speed = 8'd255;
            else               speed = 8'd0;
            pick = $urandom_range(0, 9);
            if (pick < 5)      len = 8'($urandom_range(5, 12));
            else if (pick < 7) len = 8'($urandom_range(0, 4));
            else if (pick < 9) len = 8'($urandom_range(13, MAX_CHARS));
            else               len = 8'($urandom_range(MAX_CHARS + 1, 127));
            run_phase(speed, len, ($urandom_range(0, 4) != 0), $urandom_range(60, 200), 1,
                      $urandom_range(0, 1), -1);
            rand_phases++;
        end

        // Every item has made its transfer. Open the output side, wait for the
        // last results and a settling stretch, then report.
        rx_open = 1'b1;
        drain();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
